FILE: design/bpmm_pkg.sv
// Package for the battery power mode manager: event codes, mode codes,
// register indexes and the structs passed between the top level and the event logic.
// Depends on nothing.
package bpmm_pkg;

    localparam logic [2:0] FUNC_REPORT    = 3'd0;
    localparam logic [2:0] FUNC_SENT_OK   = 3'd1;
    localparam logic [2:0] FUNC_SENT_FAIL = 3'd2;
    localparam logic [2:0] FUNC_COMMAND   = 3'd3;
    localparam logic [2:0] FUNC_DATA      = 3'd4;

    localparam logic [7:0] MODE_NORMAL    = 8'd0;
    localparam logic [7:0] MODE_SAFE      = 8'd1;
    localparam logic [7:0] MODE_EMERGENCY = 8'd2;

    localparam logic [2:0] CFG_SAFE_THRESHOLD     = 3'd0;
    localparam logic [2:0] CFG_NORMAL_THRESHOLD   = 3'd1;
    localparam logic [2:0] CFG_CRITICAL_THRESHOLD = 3'd2;
    localparam logic [2:0] CFG_SLEEP_INTERVALS    = 3'd3;
    localparam logic [2:0] CFG_RELAY_ENABLE       = 3'd4;
    localparam logic [2:0] CFG_ACCESS_KEY         = 3'd5;
    localparam logic [2:0] CFG_RECEIVER_MAC       = 3'd6;

    localparam logic [11:0] RST_SAFE_THRESHOLD     = 12'd2978;
    localparam logic [11:0] RST_NORMAL_THRESHOLD   = 12'd3226;
    localparam logic [11:0] RST_CRITICAL_THRESHOLD = 12'd2730;
    localparam logic [47:0] RST_SLEEP_INTERVALS    = 48'd15732751;
    localparam logic [31:0] RST_ACCESS_KEY         = 32'hDEADBEEF;
    localparam logic [15:0] RST_SLEEP_SEL          = 16'd15;
    localparam logic [7:0]  FAIL_COUNT_MAX         = 8'hFF;

    typedef struct packed {
        logic [2:0]  func;
        logic [11:0] battery_code;
        logic [31:0] now_minutes;
        logic [47:0] sender_mac;
        logic [31:0] cmd_auth;
        logic        target_match;
        logic [7:0]  cmd_mode;
        logic [31:0] cmd_duration;
        logic        own_origin;
    } t_event;

    typedef struct packed {
        logic [11:0] safe_threshold;
        logic [11:0] normal_threshold;
        logic [11:0] critical_threshold;
        logic [47:0] sleep_intervals;
        logic        relay_enable;
        logic [31:0] access_key;
        logic [47:0] receiver_mac;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  mode;
        logic [31:0] start;
        logic [31:0] hold;
        logic [7:0]  fail_count;
        logic [15:0] sleep_sel;
        logic [31:0] seq_count;
    } t_state;

    typedef struct packed {
        logic command_accepted;
        logic relay_command;
        logic forward_data;
    } t_flags;

endpackage

FILE: design/battery_power_mode_manager_core.sv
// Top level of the battery power mode manager: input register, node state,
// configuration registers and result register. Depends on bpmm_pkg and bpmm_event.
//
//   Channel   Handshake                Moves
//   input     i_valid / o_stall        one event word
//   result    o_valid / i_stall        one result word
//   config    i_cfg_valid / o_cfg_ready  register index and data
//
// An event is registered on entry and its result is registered as it leaves the input register,
// so one event is taken in every cycle while the result is not stalled.
// The node state is updated when an event moves into the result register.
// A stalled result holds the input register; the input side stalls only when both
// registers are full and the result is stalled.
// Reset is synchronous and active low; configuration writes are always ready.
module battery_power_mode_manager_core #(
    parameter int MAX_FAILED = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [11:0] i_battery_code,
    input  logic [31:0] i_now_minutes,
    input  logic [47:0] i_sender_mac,
    input  logic [31:0] i_cmd_auth,
    input  logic        i_target_match,
    input  logic [7:0]  i_cmd_mode,
    input  logic [31:0] i_cmd_duration,
    input  logic        i_own_origin,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_node_mode,
    output logic [15:0] o_sleep_interval,
    output logic [7:0]  o_failed_count,
    output logic [31:0] o_sequence_res,
    output logic        o_command_accepted,
    output logic        o_relay_command,
    output logic        o_forward_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    logic             r_in_valid;
    bpmm_pkg::t_event r_event;
    logic             r_out_valid;
    bpmm_pkg::t_state r_state;
    bpmm_pkg::t_flags r_flags;
    bpmm_pkg::t_cfg   r_cfg;
    bpmm_pkg::t_state n_state;
    bpmm_pkg::t_flags n_flags;
    logic             w_load;
    logic             w_accept;

    assign w_load      = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_in_valid && !w_load;
    assign w_accept    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    bpmm_event #(
        .MAX_FAILED(MAX_FAILED)
    ) u_event (
        .i_event(r_event),
        .i_state(r_state),
        .i_cfg  (r_cfg),
        .o_state(n_state),
        .o_flags(n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_event.func         <= i_func;
            r_event.battery_code <= i_battery_code;
            r_event.now_minutes  <= i_now_minutes;
            r_event.sender_mac   <= i_sender_mac;
            r_event.cmd_auth     <= i_cmd_auth;
            r_event.target_match <= i_target_match;
            r_event.cmd_mode     <= i_cmd_mode;
            r_event.cmd_duration <= i_cmd_duration;
            r_event.own_origin   <= i_own_origin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_flags     <= '0;
            r_state     <= '{mode: bpmm_pkg::MODE_NORMAL, start: '0, hold: '0,
                             fail_count: '0, sleep_sel: bpmm_pkg::RST_SLEEP_SEL,
                             seq_count: '0};
        end else if (w_load) begin
            r_out_valid <= 1'b1;
            r_flags     <= n_flags;
            r_state     <= n_state;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{safe_threshold: bpmm_pkg::RST_SAFE_THRESHOLD,
                       normal_threshold: bpmm_pkg::RST_NORMAL_THRESHOLD,
                       critical_threshold: bpmm_pkg::RST_CRITICAL_THRESHOLD,
                       sleep_intervals: bpmm_pkg::RST_SLEEP_INTERVALS,
                       relay_enable: 1'b0,
                       access_key: bpmm_pkg::RST_ACCESS_KEY,
                       receiver_mac: '0};
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bpmm_pkg::CFG_SAFE_THRESHOLD:     r_cfg.safe_threshold     <= i_cfg_data[11:0];
                bpmm_pkg::CFG_NORMAL_THRESHOLD:   r_cfg.normal_threshold   <= i_cfg_data[11:0];
                bpmm_pkg::CFG_CRITICAL_THRESHOLD: r_cfg.critical_threshold <= i_cfg_data[11:0];
                bpmm_pkg::CFG_SLEEP_INTERVALS:    r_cfg.sleep_intervals    <= i_cfg_data;
                bpmm_pkg::CFG_RELAY_ENABLE:       r_cfg.relay_enable       <= i_cfg_data[0];
                bpmm_pkg::CFG_ACCESS_KEY:         r_cfg.access_key         <= i_cfg_data[31:0];
                bpmm_pkg::CFG_RECEIVER_MAC:       r_cfg.receiver_mac       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_valid            = r_out_valid;
    assign o_node_mode        = r_state.mode;
    assign o_sleep_interval   = r_state.sleep_sel;
    assign o_failed_count     = r_state.fail_count;
    assign o_sequence_res     = r_state.seq_count;
    assign o_command_accepted = r_flags.command_accepted;
    assign o_relay_command    = r_flags.relay_command;
    assign o_forward_data     = r_flags.forward_data;

    a_forward_data_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_forward_data |-> (o_node_mode < bpmm_pkg::MODE_EMERGENCY))
        else $error("Data relay flagged in emergency or commanded mode.");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_command_accepted |-> !o_forward_data)
        else $error("Command acceptance and data relay flagged together.");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(w_load) |-> $stable(r_state))
        else $error("Node state changed without an event being loaded.");

    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && (r_event.func != bpmm_pkg::FUNC_REPORT) |=> $stable(r_state.seq_count))
        else $error("Sequence number moved on an event other than a report.");

endmodule

FILE: design/bpmm_event.sv
// Event logic of the battery power mode manager: next node state and command and relay flags
// for one registered event. Depends on bpmm_pkg.
module bpmm_event #(
    parameter int MAX_FAILED = 3
) (
    input  bpmm_pkg::t_event i_event,
    input  bpmm_pkg::t_state i_state,
    input  bpmm_pkg::t_cfg   i_cfg,
    output bpmm_pkg::t_state o_state,
    output bpmm_pkg::t_flags o_flags
);

    always_comb begin
        bpmm_pkg::t_state n_state;
        bpmm_pkg::t_flags n_flags;
        logic             check;
        logic [31:0]      elapsed;

        n_state = i_state;
        n_flags = '0;
        check   = 1'b0;

        case (i_event.func)
            bpmm_pkg::FUNC_REPORT: begin
                check             = 1'b1;
                n_state.seq_count = i_state.seq_count + 32'd1;
            end
            bpmm_pkg::FUNC_SENT_OK: begin
                n_state.fail_count = '0;
            end
            bpmm_pkg::FUNC_SENT_FAIL: begin
                if (i_state.fail_count != bpmm_pkg::FAIL_COUNT_MAX) begin
                    n_state.fail_count = i_state.fail_count + 8'd1;
                end
            end
            bpmm_pkg::FUNC_COMMAND: begin
                if (i_event.cmd_auth == i_cfg.access_key) begin
                    if (i_event.target_match) begin
                        n_state.mode             = i_event.cmd_mode;
                        n_state.hold             = i_event.cmd_duration;
                        n_state.start            = i_event.now_minutes;
                        check                    = 1'b1;
                        n_flags.command_accepted = 1'b1;
                    end
                    if (i_cfg.relay_enable && (i_event.sender_mac == i_cfg.receiver_mac)) begin
                        n_flags.relay_command = 1'b1;
                    end
                end
            end
            bpmm_pkg::FUNC_DATA: begin
                if (i_cfg.relay_enable && !i_event.own_origin &&
                    (i_state.mode < bpmm_pkg::MODE_EMERGENCY)) begin
                    n_flags.forward_data = 1'b1;
                end
            end
            default: begin
            end
        endcase

        elapsed = i_event.now_minutes - n_state.start;
        if (check) begin
            if ((n_state.hold != '0) && (elapsed >= n_state.hold)) begin
                n_state.mode = bpmm_pkg::MODE_NORMAL;
                n_state.hold = '0;
            end
            if ((n_state.mode == bpmm_pkg::MODE_NORMAL) &&
                (i_event.battery_code < i_cfg.safe_threshold)) begin
                n_state.mode  = bpmm_pkg::MODE_SAFE;
                n_state.start = i_event.now_minutes;
            end else if ((n_state.mode == bpmm_pkg::MODE_SAFE) &&
                         (i_event.battery_code > i_cfg.normal_threshold)) begin
                n_state.mode = bpmm_pkg::MODE_NORMAL;
            end
            if (i_event.battery_code < i_cfg.critical_threshold) begin
                n_state.mode = bpmm_pkg::MODE_EMERGENCY;
            end
            if ((n_state.fail_count >= 8'(MAX_FAILED)) &&
                (n_state.mode == bpmm_pkg::MODE_NORMAL)) begin
                n_state.mode  = bpmm_pkg::MODE_SAFE;
                n_state.start = i_event.now_minutes;
            end
            if (n_state.mode == bpmm_pkg::MODE_NORMAL) begin
                n_state.sleep_sel = i_cfg.sleep_intervals[15:0];
            end else if (n_state.mode == bpmm_pkg::MODE_SAFE) begin
                n_state.sleep_sel = i_cfg.sleep_intervals[31:16];
            end else if (n_state.mode == bpmm_pkg::MODE_EMERGENCY) begin
                n_state.sleep_sel = i_cfg.sleep_intervals[47:32];
            end
        end

        o_state = n_state;
        o_flags = n_flags;
    end

endmodule

FILE: tb/battery_power_mode_manager_core_tb.sv
// Self-checking testbench for battery_power_mode_manager_core: directed and random event words
// are checked against a cycle-free model of the node state, across several register settings.
// Depends on bpmm_pkg and the design under test.
module battery_power_mode_manager_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FAILED  = 3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [7:0]  mode;
        logic [15:0] sleep;
        logic [7:0]  fails;
        logic [31:0] seq;
        logic        accepted;
        logic        relay_cmd;
        logic        relay_dat;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_func = '0;
    logic [11:0] i_battery_code = '0;
    logic [31:0] i_now_minutes = '0;
    logic [47:0] i_sender_mac = '0;
    logic [31:0] i_cmd_auth = '0;
    logic        i_target_match = 1'b0;
    logic [7:0]  i_cmd_mode = '0;
    logic [31:0] i_cmd_duration = '0;
    logic        i_own_origin = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_node_mode;
    logic [15:0] o_sleep_interval;
    logic [7:0]  o_failed_count;
    logic [31:0] o_sequence_res;
    logic        o_command_accepted;
    logic        o_relay_command;
    logic        o_forward_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;

    battery_power_mode_manager_core #(.MAX_FAILED(MAX_FAILED)) dut (.*);

    always #6 i_clk = ~i_clk;

    logic [11:0] safe_thr_q = bpmm_pkg::RST_SAFE_THRESHOLD;
    logic [11:0] normal_thr_q = bpmm_pkg::RST_NORMAL_THRESHOLD;
    logic [11:0] crit_thr_q = bpmm_pkg::RST_CRITICAL_THRESHOLD;
    logic [47:0] intervals_q = bpmm_pkg::RST_SLEEP_INTERVALS;
    logic        relay_q = 1'b0;
    logic [31:0] key_q = bpmm_pkg::RST_ACCESS_KEY;
    logic [47:0] mac_q = '0;

    logic [7:0]  mode_q = bpmm_pkg::MODE_NORMAL;
    logic [31:0] start_q = '0;
    logic [31:0] hold_q = '0;
    logic [7:0]  fails_q = '0;
    logic [15:0] sleep_q = bpmm_pkg::RST_SLEEP_SEL;
    logic [31:0] seq_q = '0;

    bpmm_pkg::t_event event_backlog[$];
    t_result          due_results[$];
    bpmm_pkg::t_event cur_ev;
    logic [31:0]      clock_base = '0;

    int n_items = 0;
    int n_results = 0;
    int n_accepted = 0;
    int n_relays = 0;
    int n_cfg_writes = 0;
    int n_errors = 0;
    int cycle_count = 0;

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        n_errors++;
    endtask

    task automatic check_mode(input logic [11:0] code, input logic [31:0] now);
        logic [31:0] elapsed;
        elapsed = now - start_q;
        if (hold_q != 0 && elapsed >= hold_q) begin
            mode_q = bpmm_pkg::MODE_NORMAL;
            hold_q = '0;
        end
        if (mode_q == bpmm_pkg::MODE_NORMAL && code < safe_thr_q) begin
            mode_q = bpmm_pkg::MODE_SAFE;
            start_q = now;
        end else if (mode_q == bpmm_pkg::MODE_SAFE && code > normal_thr_q) begin
            mode_q = bpmm_pkg::MODE_NORMAL;
        end
        if (code < crit_thr_q)
            mode_q = bpmm_pkg::MODE_EMERGENCY;
        if (fails_q >= MAX_FAILED && mode_q == bpmm_pkg::MODE_NORMAL) begin
            mode_q = bpmm_pkg::MODE_SAFE;
            start_q = now;
        end
        if (mode_q == bpmm_pkg::MODE_NORMAL)
            sleep_q = intervals_q[15:0];
        else if (mode_q == bpmm_pkg::MODE_SAFE)
            sleep_q = intervals_q[31:16];
        else if (mode_q == bpmm_pkg::MODE_EMERGENCY)
            sleep_q = intervals_q[47:32];
    endtask

    task automatic advance_node(input bpmm_pkg::t_event ev, output t_result r);
        r = '0;
        case (ev.func)
            bpmm_pkg::FUNC_REPORT: begin
                check_mode(ev.battery_code, ev.now_minutes);
                seq_q = seq_q + 32'd1;
            end
            bpmm_pkg::FUNC_SENT_OK: fails_q = '0;
            bpmm_pkg::FUNC_SENT_FAIL: begin
                if (fails_q != bpmm_pkg::FAIL_COUNT_MAX) fails_q = fails_q + 8'd1;
            end
            bpmm_pkg::FUNC_COMMAND: begin
                if (ev.cmd_auth == key_q) begin
                    if (ev.target_match) begin
                        mode_q = ev.cmd_mode;
                        hold_q = ev.cmd_duration;
                        start_q = ev.now_minutes;
                        check_mode(ev.battery_code, ev.now_minutes);
                        r.accepted = 1'b1;
                    end
                    if (relay_q && ev.sender_mac == mac_q)
                        r.relay_cmd = 1'b1;
                end
            end
            bpmm_pkg::FUNC_DATA: begin
                if (relay_q && !ev.own_origin && mode_q < bpmm_pkg::MODE_EMERGENCY)
                    r.relay_dat = 1'b1;
            end
            default: ;
        endcase
        r.mode = mode_q;
        r.sleep = sleep_q;
        r.fails = fails_q;
        r.seq = seq_q;
    endtask

    function automatic bpmm_pkg::t_event mk(input logic [2:0] f, input logic [11:0] code,
                                  input logic [31:0] now, input logic [47:0] snd,
                                  input logic [31:0] au, input logic tgt, input logic [7:0] md,
                                  input logic [31:0] dur, input logic own);
        bpmm_pkg::t_event ev;
        ev.func = f;
        ev.battery_code = code;
        ev.now_minutes = now;
        ev.sender_mac = snd;
        ev.cmd_auth = au;
        ev.target_match = tgt;
        ev.cmd_mode = md;
        ev.cmd_duration = dur;
        ev.own_origin = own;
        return ev;
    endfunction

    function automatic bpmm_pkg::t_event roll_event();
        bpmm_pkg::t_event ev;
        int unsigned pick;
        logic [11:0] thr;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            ev.func = bpmm_pkg::FUNC_REPORT;
        else if (pick < 48)
            ev.func = bpmm_pkg::FUNC_SENT_FAIL;
        else if (pick < 56)
            ev.func = bpmm_pkg::FUNC_SENT_OK;
        else if (pick < 80)
            ev.func = bpmm_pkg::FUNC_COMMAND;
        else if (pick < 94)
            ev.func = bpmm_pkg::FUNC_DATA;
        else
            ev.func = bpmm_pkg::FUNC_DATA + 3'($urandom_range(1, 3));
        case ($urandom_range(0, 3))
            0: thr = 12'($urandom());
            1: thr = safe_thr_q;
            2: thr = normal_thr_q;
            default: thr = crit_thr_q;
        endcase
        ev.battery_code = thr + 12'($urandom_range(0, 8)) - 12'd4;
        if ($urandom_range(0, 49) == 0)
            clock_base = $urandom();
        else
            clock_base = clock_base + $urandom_range(0, 6);
        ev.now_minutes = clock_base;
        ev.sender_mac = $urandom_range(0, 1) ? mac_q : 48'({$urandom(), $urandom()});
        ev.cmd_auth = ($urandom_range(0, 9) < 8) ? key_q : $urandom();
        ev.target_match = $urandom_range(0, 9) < 7;
        ev.cmd_mode = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 3))
                                                   : 8'($urandom());
        pick = $urandom_range(0, 9);
        ev.cmd_duration = (pick < 3) ? 32'd0 : (pick < 8) ? 32'($urandom_range(1, 20))
                                                          : $urandom();
        ev.own_origin = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [47:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            bpmm_pkg::CFG_SAFE_THRESHOLD:     safe_thr_q = val[11:0];
            bpmm_pkg::CFG_NORMAL_THRESHOLD:   normal_thr_q = val[11:0];
            bpmm_pkg::CFG_CRITICAL_THRESHOLD: crit_thr_q = val[11:0];
            bpmm_pkg::CFG_SLEEP_INTERVALS:    intervals_q = val;
            bpmm_pkg::CFG_RELAY_ENABLE:       relay_q = val[0];
            bpmm_pkg::CFG_ACCESS_KEY:         key_q = val[31:0];
            bpmm_pkg::CFG_RECEIVER_MAC:       mac_q = val;
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    task automatic cfg_all(input logic [11:0] s, input logic [11:0] n, input logic [11:0] c,
                           input logic [47:0] iv, input logic rl, input logic [31:0] au,
                           input logic [47:0] mac);
        cfg_write(bpmm_pkg::CFG_SAFE_THRESHOLD, 48'(s));
        cfg_write(bpmm_pkg::CFG_NORMAL_THRESHOLD, 48'(n));
        cfg_write(bpmm_pkg::CFG_CRITICAL_THRESHOLD, 48'(c));
        cfg_write(bpmm_pkg::CFG_SLEEP_INTERVALS, iv);
        cfg_write(bpmm_pkg::CFG_RELAY_ENABLE, 48'(rl));
        cfg_write(bpmm_pkg::CFG_ACCESS_KEY, 48'(au));
        cfg_write(bpmm_pkg::CFG_RECEIVER_MAC, mac);
    endtask

    task automatic drain();
        do @(negedge i_clk); while (event_backlog.size() != 0 || due_results.size() != 0
                                    || i_valid);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic queue_random(input int count);
        @(negedge i_clk);
        repeat (count) event_backlog.push_back(roll_event());
        drain();
    endtask

    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_result r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                advance_node(cur_ev, r);
                due_results.push_back(r);
                n_items++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (event_backlog.size() != 0) begin
                    cur_ev = event_backlog.pop_front();
                    i_func <= cur_ev.func;
                    i_battery_code <= cur_ev.battery_code;
                    i_now_minutes <= cur_ev.now_minutes;
                    i_sender_mac <= cur_ev.sender_mac;
                    i_cmd_auth <= cur_ev.cmd_auth;
                    i_target_match <= cur_ev.target_match;
                    i_cmd_mode <= cur_ev.cmd_mode;
                    i_cmd_duration <= cur_ev.cmd_duration;
                    i_own_origin <= cur_ev.own_origin;
                    i_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    int rx_style = 0;
    int rx_hold_left = 0;
    bit rx_hold_done = 1'b0;

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected word", {40'd0, o_node_mode}, '0);
                end else begin
                    want = due_results.pop_front();
                    if (o_node_mode !== want.mode)
                        report_mismatch("node mode", 48'(o_node_mode), 48'(want.mode));
                    if (o_sleep_interval !== want.sleep)
                        report_mismatch("sleep interval", 48'(o_sleep_interval),
                                        48'(want.sleep));
                    if (o_failed_count !== want.fails)
                        report_mismatch("failed_count", 48'(o_failed_count), 48'(want.fails));
                    if (o_sequence_res !== want.seq)
                        report_mismatch("sequence_res", 48'(o_sequence_res), 48'(want.seq));
                    if (o_command_accepted !== want.accepted)
                        report_mismatch("command_accepted", 48'(o_command_accepted),
                                        48'(want.accepted));
                    if (o_relay_command !== want.relay_cmd)
                        report_mismatch("relay_command", 48'(o_relay_command),
                                        48'(want.relay_cmd));
                    if (o_forward_data !== want.relay_dat)
                        report_mismatch("data forward", 48'(o_forward_data),
                                        48'(want.relay_dat));
                    n_accepted += int'(want.accepted);
                    n_relays += int'(want.relay_cmd) + int'(want.relay_dat);
                end
            end
            if (cycle_count % 50 == 0)
                rx_style = $urandom_range(0, 3);
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                i_stall <= 1'b1;
            end else if (!rx_hold_done && n_results >= 120) begin
                rx_hold_done = 1'b1;
                rx_hold_left = HOLD_CYCLES;
                i_stall <= 1'b1;
            end else begin
                case (rx_style)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= 1'($urandom_range(0, 1));
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("battery_power_mode_manager_core_tb failed");
            $finish;
        end
    end

    initial begin
        logic [47:0] gw;
        logic [31:0] bad;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gw = 48'hA1B2_C3D4_E5F6;
        cfg_write(bpmm_pkg::CFG_RELAY_ENABLE, 48'd1);
        cfg_write(bpmm_pkg::CFG_RECEIVER_MAC, gw);
        bad = key_q ^ 32'h0000_0001;

        @(negedge i_clk);
        event_backlog.push_back(mk(bpmm_pkg::FUNC_REPORT, 12'd4095, 32'd0, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_REPORT, 12'd2900, 32'd5, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_REPORT, 12'd3000, 32'd6, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_REPORT, 12'd3300, 32'd7, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_REPORT, 12'd0, 32'd8, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_REPORT, 12'd4095, 32'd9, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_COMMAND, 12'd4095, 32'd10, gw, key_q, 1'b1,
                                   bpmm_pkg::MODE_NORMAL, 32'd0, 1'b0));
        repeat (3) event_backlog.push_back(mk(bpmm_pkg::FUNC_SENT_FAIL, 12'd0, 32'd11, '0, '0,
                                              1'b0, bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_REPORT, 12'd4095, 32'd12, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_SENT_OK, 12'd0, 32'd13, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_REPORT, 12'd4095, 32'd14, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_COMMAND, 12'd0, 32'd15, gw, bad, 1'b1,
                                   bpmm_pkg::MODE_EMERGENCY, 32'd0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_COMMAND, 12'd0, 32'd16, gw, key_q, 1'b0,
                                   bpmm_pkg::MODE_EMERGENCY, 32'd0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_COMMAND, 12'd4095, 32'd100, '1, key_q, 1'b1,
                                   8'hFF, 32'd10, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_DATA, 12'd0, 32'd101, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_REPORT, 12'd4095, 32'd105, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_REPORT, 12'd4095, 32'd110, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_COMMAND, 12'd4095, '1, '1, key_q, 1'b1,
                                   8'd3, '1, 1'b1));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_REPORT, 12'd4095, 32'd0, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_COMMAND, 12'd4095, 32'd1, gw, key_q, 1'b1,
                                   bpmm_pkg::MODE_SAFE, 32'd0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_DATA, 12'd0, 32'd2, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_DATA, 12'd0, 32'd3, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b1));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_DATA + 3'd1, '1, '1, '1, '1, 1'b1, '1, '1,
                                   1'b1));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_DATA + 3'd2, 12'd0, 32'd4, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        event_backlog.push_back(mk(bpmm_pkg::FUNC_DATA + 3'd3, 12'd0, 32'd5, '0, '0, 1'b0,
                                   bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        drain();

        queue_random(40);

        @(negedge i_clk);
        repeat (258) event_backlog.push_back(mk(bpmm_pkg::FUNC_SENT_FAIL, 12'($urandom()),
                                                $urandom(), '0, '0, 1'b0,
                                                bpmm_pkg::MODE_NORMAL, '0, 1'b0));
        drain();
        queue_random(10);

        cfg_all(12'($urandom()), 12'($urandom()), 12'($urandom()),
                48'({$urandom(), $urandom()}), 1'b1, $urandom(), 48'({$urandom(), $urandom()}));
        queue_random(30);

        cfg_all('1, '0, '0, '1, 1'b0, '0, '1);
        queue_random(15);

        cfg_all('0, '1, '1, '0, 1'b1, '1, '0);
        queue_random(15);

        cfg_all(bpmm_pkg::RST_SAFE_THRESHOLD, bpmm_pkg::RST_NORMAL_THRESHOLD,
                bpmm_pkg::RST_CRITICAL_THRESHOLD, bpmm_pkg::RST_SLEEP_INTERVALS, 1'b1,
                bpmm_pkg::RST_ACCESS_KEY, gw);
        queue_random(15);

        repeat (10) @(negedge i_clk);
        if (due_results.size() != 0)
            report_mismatch("words never delivered", 48'(due_results.size()), '0);

        $display("Run covered %0d events and %0d result words, %0d commands accepted, %0d relays.",
                 n_items, n_results, n_accepted, n_relays);
        $display("%0d register writes over five settings, with failure-count saturation.",
                 n_cfg_writes);
        if (n_errors == 0)
            $display("battery_power_mode_manager_core_tb passed");
        else
            $display("battery_power_mode_manager_core_tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/bpmm_pkg.sv
design/bpmm_event.sv
design/battery_power_mode_manager_core.sv
tb/battery_power_mode_manager_core_tb.sv
